// ===== hw/rtl/dssfb_pkg.sv =====
package dssfb_pkg;

    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned POINT_W   = 3;
    localparam int unsigned STATUS_W  = 8;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned NUM_DISP  = 2;
    localparam int unsigned NUM_DIG   = 4;
    localparam int unsigned FRAME_LEN = 17;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

    localparam logic [VALUE_W-1:0] MAX_SHOWN = 16'd9999;
    localparam logic [BYTE_W-1:0]  ADDR_CMD  = 8'hC0;
    localparam logic [BYTE_W-1:0]  IND_ON    = 8'hFF;
    localparam logic [BYTE_W-1:0]  IND_OFF   = 8'h00;
    localparam logic [BYTE_W-1:0]  POINT_BIT = 8'h80;

    // reciprocal multipliers, exact for values up to 9999
    localparam logic [31:0] RECIP_1000 = 32'd16778;
    localparam int unsigned SH_1000    = 24;
    localparam logic [31:0] RECIP_100  = 32'd5243;
    localparam int unsigned SH_100     = 19;
    localparam logic [31:0] RECIP_10   = 32'd6554;
    localparam int unsigned SH_10      = 16;

    // segment table codes beyond the decimal digits
    localparam logic [3:0] SEG_BLANK  = 4'd10;
    localparam logic [3:0] SEG_HYPHEN = 4'd11;

    typedef logic [NUM_DIG-1:0][BYTE_W-1:0] t_disp_segs;

    typedef struct packed {
        logic [NUM_DISP-1:0][NUM_DIG-1:0][BYTE_W-1:0] segs;
        logic [STATUS_W-1:0]                          status;
    } t_frame;

    function automatic logic [BYTE_W-1:0] seg_lookup(input logic [3:0] code);
        logic [BYTE_W-1:0] s;
        case (code)
            4'd0:       s = 8'h3F;
            4'd1:       s = 8'h06;
            4'd2:       s = 8'h5B;
            4'd3:       s = 8'h4F;
            4'd4:       s = 8'h66;
            4'd5:       s = 8'h6D;
            4'd6:       s = 8'h7D;
            4'd7:       s = 8'h07;
            4'd8:       s = 8'h7F;
            4'd9:       s = 8'h6F;
            SEG_BLANK:  s = 8'h00;
            SEG_HYPHEN: s = 8'h40;
            default:    s = 8'h00;
        endcase
        return s;
    endfunction

    // digits from the quotients, blanking, segment codes and the point
    function automatic t_disp_segs build_segs(
        input logic               hyph,
        input logic [3:0]         q1000,
        input logic [6:0]         q100,
        input logic [9:0]         q10,
        input logic [13:0]        val,
        input logic [POINT_W-1:0] point
    );
        logic [3:0][3:0] code;
        logic [13:0]     t2;
        logic [13:0]     t1;
        logic [13:0]     t0;
        t_disp_segs      segs;
        t2 = 14'(q100) - 14'({q1000, 3'b000}) - 14'({q1000, 1'b0});
        t1 = 14'(q10)  - 14'({q100, 3'b000})  - 14'({q100, 1'b0});
        t0 = val       - 14'({q10, 3'b000})   - 14'({q10, 1'b0});
        code[3] = q1000;
        code[2] = t2[3:0];
        code[1] = t1[3:0];
        code[0] = t0[3:0];
        if (code[3] == 4'd0) begin
            code[3] = SEG_BLANK;
        end
        if (code[2] == 4'd0 && code[3] == SEG_BLANK) begin
            code[2] = SEG_BLANK;
        end
        if (code[1] == 4'd0 && code[2] == SEG_BLANK) begin
            code[1] = SEG_BLANK;
        end
        for (int x = 0; x < NUM_DIG; x++) begin
            segs[x] = seg_lookup(hyph ? SEG_HYPHEN : code[x]);
            if (point[POINT_W-1] == 1'b0 && point[1:0] == 2'(x)) begin
                segs[x] = segs[x] | POINT_BIT;
            end
        end
        return segs;
    endfunction

endpackage

// ===== hw/rtl/dssfb_if.sv =====
interface dssfb_req_if;
    logic              valid;
    logic              ready;
    logic [15:0]       rpm_value;
    logic signed [2:0] rpm_point;
    logic [15:0]       pitch_value;
    logic signed [2:0] pitch_point;
    logic [7:0]        status_bits;

    modport source (output valid, output rpm_value, output rpm_point, output pitch_value,
                    output pitch_point, output status_bits, input ready);
    modport sink   (input valid, input rpm_value, input rpm_point, input pitch_value,
                    input pitch_point, input status_bits, output ready);
endinterface

interface dssfb_frm_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       is_command;
    logic       last_byte;

    modport source (output valid, output frame_byte, output is_command, output last_byte,
                    input ready);
    modport sink   (input valid, input frame_byte, input is_command, input last_byte,
                    output ready);
endinterface

// ===== hw/rtl/dssfb_split.sv =====
module dssfb_split (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dssfb_req_if.sink       i_req,
    output logic            o_frm_vld,
    input  logic            i_frm_rdy,
    output dssfb_pkg::t_frame o_frm
);
    import dssfb_pkg::*;

    // stage 1: reciprocal quotients
    logic                                 r_s1_vld;
    logic [NUM_DISP-1:0]                  r_s1_hyph;
    logic [NUM_DISP-1:0][3:0]             r_s1_q1000;
    logic [NUM_DISP-1:0][6:0]             r_s1_q100;
    logic [NUM_DISP-1:0][9:0]             r_s1_q10;
    logic [NUM_DISP-1:0][13:0]            r_s1_val;
    logic [NUM_DISP-1:0][POINT_W-1:0]     r_s1_point;
    logic [STATUS_W-1:0]                  r_s1_status;

    // stage 2: finished segment bytes
    logic   r_s2_vld;
    t_frame r_s2_frm;

    logic                          s1_adv;
    logic                          s2_adv;
    logic [NUM_DISP-1:0][VALUE_W-1:0] in_val;
    logic [NUM_DISP-1:0][31:0]     p1000;
    logic [NUM_DISP-1:0][31:0]     p100;
    logic [NUM_DISP-1:0][31:0]     p10;
    t_frame                        n_s2_frm;

    assign s2_adv      = !r_s2_vld || i_frm_rdy;
    assign s1_adv      = !r_s1_vld || s2_adv;
    assign i_req.ready = s1_adv;

    assign in_val[0] = i_req.rpm_value;
    assign in_val[1] = i_req.pitch_value;

    always_comb begin
        for (int d = 0; d < NUM_DISP; d++) begin
            p1000[d] = 32'(in_val[d]) * RECIP_1000;
            p100[d]  = 32'(in_val[d]) * RECIP_100;
            p10[d]   = 32'(in_val[d]) * RECIP_10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_req.valid) begin
            for (int d = 0; d < NUM_DISP; d++) begin
                r_s1_hyph[d]  <= in_val[d] > MAX_SHOWN;
                r_s1_q1000[d] <= 4'(p1000[d] >> SH_1000);
                r_s1_q100[d]  <= 7'(p100[d] >> SH_100);
                r_s1_q10[d]   <= 10'(p10[d] >> SH_10);
                r_s1_val[d]   <= in_val[d][13:0];
            end
            r_s1_point[0] <= i_req.rpm_point;
            r_s1_point[1] <= i_req.pitch_point;
            r_s1_status   <= i_req.status_bits;
        end
    end

    always_comb begin
        for (int d = 0; d < NUM_DISP; d++) begin
            n_s2_frm.segs[d] = build_segs(r_s1_hyph[d], r_s1_q1000[d], r_s1_q100[d],
                                          r_s1_q10[d], r_s1_val[d], r_s1_point[d]);
        end
        n_s2_frm.status = r_s1_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s2_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_vld) begin
            r_s2_frm <= n_s2_frm;
        end
    end

    assign o_frm_vld = r_s2_vld;
    assign o_frm     = r_s2_frm;

endmodule

// ===== hw/rtl/dssfb_serial.sv =====
module dssfb_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_frm_vld,
    output logic              o_frm_rdy,
    input  dssfb_pkg::t_frame i_frm,
    dssfb_frm_if.source       o_out
);
    import dssfb_pkg::*;

    t_frame            r_frm;
    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovld;
    logic [BYTE_W-1:0] r_obyte;
    logic              r_ocmd;
    logic              r_olast;

    logic              out_adv;
    logic              emit;
    logic              at_last;
    logic              take;
    logic [3:0]        j;
    logic [1:0]        x;
    logic [BYTE_W-1:0] n_byte;

    assign out_adv   = !r_ovld || o_out.ready;
    assign emit      = r_busy && out_adv;
    assign at_last   = r_cnt == CNT_W'(FRAME_LEN - 1);
    assign o_frm_rdy = !r_busy || (emit && at_last);
    assign take      = o_frm_rdy && i_frm_vld;

    // byte j after the command: digit on even j, its indicator on odd j
    assign j = 4'(r_cnt - CNT_W'(1));
    assign x = ~j[2:1];

    always_comb begin
        if (r_cnt == '0) begin
            n_byte = ADDR_CMD;
        end else if (!j[0]) begin
            n_byte = r_frm.segs[j[3]][x];
        end else begin
            n_byte = r_frm.status[{~j[3], x}] ? IND_ON : IND_OFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
        end else begin
            if (take) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (emit) begin
                if (at_last) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (out_adv) begin
                r_ovld <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_frm <= i_frm;
        end
        if (emit) begin
            r_obyte <= n_byte;
            r_ocmd  <= r_cnt == '0;
            r_olast <= at_last;
        end
    end

    assign o_out.valid      = r_ovld;
    assign o_out.frame_byte = r_obyte;
    assign o_out.is_command = r_ocmd;
    assign o_out.last_byte  = r_olast;

endmodule

// ===== hw/rtl/dual_seven_segment_frame_builder.sv =====
// dual seven-segment frame builder
//
// i_req takes one request word: two 16-bit display values, a decimal-point
// digit index for each (0 = units .. 3 = thousands, negative = none) and
// eight indicator bits. o_frm gives seventeen words per request, one byte
// each: the address command 0xc0 flagged by is_command, then for the first
// and then the second display the four digits from the most significant,
// each digit followed by its indicator byte (0xff or 0x00). last_byte marks
// the seventeenth word.
// a request's command byte passes the two digit stages and the serializer's
// frame register into the output register. the byte serializer sends one byte
// per cycle while the receiver takes them; the two digit stages ahead of it
// already hold the next request so frames follow with no gap.
// reset clears all valid flags and the byte counter; the block then takes
// a request at once. when the receiver stalls, the output word holds and
// the serializer and digit stages fill up before i_req.ready drops.
module dual_seven_segment_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dssfb_req_if.sink   i_req,
    dssfb_frm_if.source o_frm
);
    import dssfb_pkg::*;

    // digit words passed from the split stages to the serializer
    logic   frm_vld;
    logic   frm_rdy;
    t_frame frm;

    // reciprocal divide, digit recovery, blanking and segment lookup
    dssfb_split u_split (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_frm_vld (frm_vld),
        .i_frm_rdy (frm_rdy),
        .o_frm     (frm)
    );

    // one byte per cycle into the output register while the receiver takes them
    dssfb_serial u_serial (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_frm_vld (frm_vld),
        .o_frm_rdy (frm_rdy),
        .i_frm     (frm),
        .o_out     (o_frm)
    );

endmodule
